// ===== hdl/vector_similarity_engine_macros.svh =====
// assertion macros for the checks of this block
`ifndef VECTOR_SIMILARITY_ENGINE_MACROS_SVH
`define VECTOR_SIMILARITY_ENGINE_MACROS_SVH

// same-cycle implication
`define VSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vector_similarity_engine check failed");

// next-cycle implication
`define VSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vector_similarity_engine check failed");

`endif

// ===== hdl/vse_pkg.sv =====
`default_nettype none
package vse_pkg;
  localparam int ELEM_WIDTH = 16;
  localparam int ELEM_FRAC  = 12;
  localparam int ACC_WIDTH  = 44;
  localparam int SQRT_STEPS = 26;
  localparam int MUL_STEPS  = ACC_WIDTH;
  localparam int COS_BITS   = 17;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [1:0] {
    SEL_EUCLID,
    SEL_ZERO,
    SEL_COSINE
  } sel_t;

  typedef struct packed {
    logic             accept;
    logic             clear;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             mul_init;
    logic             mul_step;
    logic             cos_step;
    logic             load_out;
    sel_t             sel;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic cos_mode;
    logic zero_norm;
  } stat_t;
endpackage
`default_nettype wire

// ===== hdl/vse_datapath.sv =====
`default_nettype none
module vse_datapath #(
  parameter int MAX_DIM = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_metric,
  input  wire logic signed [vse_pkg::ELEM_WIDTH-1:0] query_element,
  input  wire logic signed [vse_pkg::ELEM_WIDTH-1:0] other_element,
  input  wire vse_pkg::cmd_t                     cmd,
  output vse_pkg::stat_t                         stat,
  output logic signed [31:0]                     result,
  output logic        [1:0]                      status
);
  import vse_pkg::*;

  localparam int CW = $clog2(MAX_DIM + 2);
  localparam int SW = 2 * SQRT_STEPS;
  localparam int PW = 2 * ACC_WIDTH;
  localparam int WW = 124;

  logic                          metric;
  logic signed [ELEM_WIDTH-1:0]  sq, so;
  logic                          sv;
  logic signed [ACC_WIDTH-1:0]   dot_sum;
  logic        [ACC_WIDTH-1:0]   qn_sum, on_sum, dd_sum;
  logic                          sat;
  logic        [CW-1:0]          elem_count;

  logic        [SW:0]            sx, sres;
  logic        [PW-1:0]          pa, da, pacc, dacc;
  logic        [ACC_WIDTH-1:0]   pb, db;
  logic        [WW-1:0]          cs, ct;
  logic        [COS_BITS-1:0]    cr;

  // accumulate datapath
  logic signed [31:0]            prod, qsq, osq;
  logic signed [ELEM_WIDTH:0]    diff;
  logic signed [33:0]            dsq;
  logic signed [ACC_WIDTH:0]     dot_wide;
  logic        [ACC_WIDTH:0]     qn_wide, on_wide, dd_wide;
  logic        [CW-1:0]          count_next;
  logic        [ACC_WIDTH-1:0]   dmag;

  always_comb begin
    prod = sq * so;
    qsq  = sq * sq;
    osq  = so * so;
    diff = (ELEM_WIDTH+1)'(sq) - (ELEM_WIDTH+1)'(so);
    dsq  = diff * diff;
    dot_wide = (ACC_WIDTH+1)'(dot_sum) + (ACC_WIDTH+1)'(prod);
    qn_wide  = {1'b0, qn_sum} + (ACC_WIDTH+1)'(qsq[30:0]);
    on_wide  = {1'b0, on_sum} + (ACC_WIDTH+1)'(osq[30:0]);
    dd_wide  = {1'b0, dd_sum} + (ACC_WIDTH+1)'(dsq[31:0]);
    count_next = elem_count + CW'(elem_count <= CW'(MAX_DIM));
    dmag = dot_sum[ACC_WIDTH-1] ? (~dot_sum + 1'b1) : dot_sum;
  end

  // square root step
  logic [SW:0] sbit, strial;
  always_comb begin
    sbit   = (SW+1)'(1) << {cmd.idx, 1'b0};
    strial = sres + sbit;
  end

  // cosine bit search: s = r*r*p, t = r*p kept incrementally
  logic [WW-1:0] lhs, rhs;
  always_comb begin
    rhs = WW'({dacc, 32'b0});
    lhs = cs + (ct << (cmd.idx + 1'b1)) + (WW'(pacc) << {cmd.idx, 1'b0});
  end

  logic [COS_BITS-1:0] cmag;
  always_comb begin
    cmag = (cr > COS_BITS'(65536)) ? COS_BITS'(65536) : cr;
  end

  assign stat.cos_mode  = metric;
  assign stat.zero_norm = (qn_sum == '0) || (on_sum == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      metric <= 1'b0;
      sv     <= 1'b0;
    end else begin
      if (cfg_we) metric <= cfg_metric;
      sv <= cmd.accept;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sq <= query_element;
      so <= other_element;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      dot_sum    <= '0;
      qn_sum     <= '0;
      on_sum     <= '0;
      dd_sum     <= '0;
      sat        <= 1'b0;
      elem_count <= '0;
    end else if (sv) begin
      elem_count <= count_next;
      if (dot_wide[ACC_WIDTH] != dot_wide[ACC_WIDTH-1]) begin
        dot_sum <= {dot_wide[ACC_WIDTH], {(ACC_WIDTH-1){~dot_wide[ACC_WIDTH]}}};
      end else begin
        dot_sum <= dot_wide[ACC_WIDTH-1:0];
      end
      qn_sum <= qn_wide[ACC_WIDTH] ? '1 : qn_wide[ACC_WIDTH-1:0];
      on_sum <= on_wide[ACC_WIDTH] ? '1 : on_wide[ACC_WIDTH-1:0];
      dd_sum <= dd_wide[ACC_WIDTH] ? '1 : dd_wide[ACC_WIDTH-1:0];
      if ((dot_wide[ACC_WIDTH] != dot_wide[ACC_WIDTH-1]) || qn_wide[ACC_WIDTH] ||
          on_wide[ACC_WIDTH] || dd_wide[ACC_WIDTH] || (count_next > CW'(MAX_DIM)))
        sat <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sx   <= (SW+1)'({dd_sum, 8'b0});
      sres <= '0;
    end else if (cmd.sqrt_step) begin
      if (sx >= strial) begin
        sx   <= sx - strial;
        sres <= (sres >> 1) + sbit;
      end else begin
        sres <= sres >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_init) begin
      pa   <= PW'(qn_sum);
      pb   <= on_sum;
      pacc <= '0;
      da   <= PW'(dmag);
      db   <= dmag;
      dacc <= '0;
      cs   <= '0;
      ct   <= '0;
      cr   <= '0;
    end else if (cmd.mul_step) begin
      if (pb[0]) pacc <= pacc + pa;
      if (db[0]) dacc <= dacc + da;
      pa <= pa << 1;
      da <= da << 1;
      pb <= pb >> 1;
      db <= db >> 1;
    end else if (cmd.cos_step) begin
      if (lhs <= rhs) begin
        cs <= lhs;
        ct <= ct + (WW'(pacc) << cmd.idx);
        cr <= cr | (COS_BITS'(1) << cmd.idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (cmd.sel)
        SEL_EUCLID: begin
          result <= 32'(sres);
          status <= sat ? ST_SAT : ST_OK;
        end
        SEL_ZERO: begin
          result <= '0;
          status <= ST_ZERO;
        end
        SEL_COSINE: begin
          result <= dot_sum[ACC_WIDTH-1] ? -32'(cmag) : 32'(cmag);
          status <= sat ? ST_SAT : ST_OK;
        end
        default: begin
          result <= '0;
          status <= ST_OK;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/vse_controller.sv =====
`default_nettype none
module vse_controller (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           last_element,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire vse_pkg::stat_t stat,
  output vse_pkg::cmd_t       cmd
);
  import vse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAST,
    S_DECIDE,
    S_SQRT,
    S_MUL,
    S_COS,
    S_LOAD
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  sel_t             sel;
  logic             out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd           = '0;
    cmd.sel       = sel;
    cmd.idx       = cnt[IDX_W-1:0];
    cmd.accept    = (state == S_IDLE) && in_valid;
    cmd.sqrt_step = (state == S_SQRT);
    cmd.mul_step  = (state == S_MUL);
    cmd.cos_step  = (state == S_COS);
    cmd.load_out  = (state == S_LOAD) && out_free;
    cmd.clear     = cmd.load_out;
    if (state == S_DECIDE) begin
      cmd.sqrt_init = !stat.cos_mode;
      cmd.mul_init  = stat.cos_mode && !stat.zero_norm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      sel       <= SEL_EUCLID;
    end else begin
      if (cmd.load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && last_element) state <= S_LAST;
        end
        S_LAST: state <= S_DECIDE;
        S_DECIDE: begin
          if (!stat.cos_mode) begin
            sel   <= SEL_EUCLID;
            cnt   <= CNT_W'(SQRT_STEPS - 1);
            state <= S_SQRT;
          end else if (stat.zero_norm) begin
            sel   <= SEL_ZERO;
            state <= S_LOAD;
          end else begin
            sel   <= SEL_COSINE;
            cnt   <= CNT_W'(MUL_STEPS - 1);
            state <= S_MUL;
          end
        end
        S_SQRT: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= S_LOAD;
        end
        S_MUL: begin
          if (cnt == '0) begin
            cnt   <= CNT_W'(COS_BITS - 1);
            state <= S_COS;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_COS: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/vector_similarity_engine.sv =====
`default_nettype none
// Streams element pairs of two vectors (signed Q4.12), one word per cycle,
// keeping saturating 44-bit sums of the dot product, both squared norms and
// the squared differences. A pair marked last closes the vector: the block
// then stalls its input and produces one word, either the Euclidean distance
// floor(sqrt(diff sum)) or the cosine similarity (dot / sqrt(norm product),
// truncated, clamped to 1.0) in signed Q16.16, with a status of ok, zero norm
// or saturated. Non-last pairs are taken every cycle. After a last pair the
// input stays stalled through the last and decide states and the finishing
// pass: the bit-by-bit square root loop for distance, the shift-add
// multipliers and then the quotient bit search for cosine, or none for a zero
// norm, and then the load of the output register, which is held off while
// the previous result is still waiting to be taken.
module vector_similarity_engine #(
  parameter int MAX_DIM = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // metric register write channel
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic                                  metric,
  // element pair channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [vse_pkg::ELEM_WIDTH-1:0] query_element,
  input  wire logic signed [vse_pkg::ELEM_WIDTH-1:0] other_element,
  input  wire logic                                  last_element,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [31:0]                         result,
  output logic        [1:0]                          status
);
  import vse_pkg::*;

  `include "vector_similarity_engine_macros.svh"

  cmd_t  cmd;
  stat_t stat;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  vse_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .last_element (last_element),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  vse_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_metric    (metric),
    .query_element (query_element),
    .other_element (other_element),
    .cmd           (cmd),
    .stat          (stat),
    .result        (result),
    .status        (status)
  );

  // a closing pair must hold off the next word while the result is formed
  `VSE_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && last_element, in_stall)
  // zero norm always reports a zero result
  `VSE_ASSERT_NOW(a_zero_result, out_valid && (status == ST_ZERO), result == 32'sd0)
  // a new result never overwrites one still waiting
  `VSE_ASSERT_NOW(a_no_overrun, cmd.load_out, !out_valid || !out_stall)
endmodule
`default_nettype wire
